@@ src/cidt_pkg.sv @@
// ----------------------------------------------------------------------------
// cidt_pkg
// Shared types, sizes and codes of the connection identifier table.
// ----------------------------------------------------------------------------
package cidt_pkg;

    localparam int TABLE_DEPTH   = 2048;
    localparam int SLOT_COUNT    = 256;
    localparam int MAX_KEY_BYTES = 20;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    // Request actions
    localparam logic [1:0] ACT_LOOKUP     = 2'd0;
    localparam logic [1:0] ACT_INSERT     = 2'd1;
    localparam logic [1:0] ACT_REMOVE     = 2'd2;
    localparam logic [1:0] ACT_REMOVE_ALL = 2'd3;

    // Result status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_MISS = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [63:0] key_low;
        logic [63:0] key_mid;
        logic [31:0] key_high;
        logic [4:0]  key_len;
        logic [7:0]  owner;
    } entry_t;

endpackage

@@ src/connection_id_table.sv @@
// ----------------------------------------------------------------------------
// connection_id_table
// Table of connection identifiers (up to 20 bytes plus length) mapped to an
// owning connection slot, with lookup, insert, remove and remove-by-slot.
// ----------------------------------------------------------------------------
// Usage: pulse start with the request fields while busy is low; the request
// is taken at that edge. Exactly one result word follows, shown on status
// and found_slot for the single cycle in which done is high; the receiver
// must take it then, as nothing holds it. Every request walks the single
// entry memory in address order, one entry per cycle, reading one entry
// ahead of the one being checked, so a request ends soonest when the first
// entry decides it and lasts longest when it walks the whole table.
// Lookup, insert and remove stop at the first entry that decides them;
// remove-by-slot always walks the whole table. An insert whose slot is
// beyond the slot count answers in the next cycle without a walk. After
// reset the block runs a clearing pass over all TABLE_DEPTH entries, one
// entry a cycle, with busy high, before it accepts its first request.
// Identifier bytes at or beyond the length are zeroed on entry and never
// compared; a length above 20 counts as 20.
// ----------------------------------------------------------------------------
module connection_id_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [63:0] cid_bytes_0_7,
    input  logic [63:0] cid_bytes_8_15,
    input  logic [31:0] cid_bytes_16_19,
    input  logic [4:0]  cid_length,
    input  logic [7:0]  owner_slot,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  found_slot
);
    import cidt_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    // Entry memory: one synchronous write port, one registered read port
    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Control state
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  issue_cnt_reg, issue_cnt_next;
    logic              eval_vld_reg, eval_vld_next;
    logic [ADDR_W-1:0] eval_addr_reg, eval_addr_next;
    logic              done_reg, done_next;

    // Request and result words
    logic [1:0]  act_reg, act_next;
    logic [63:0] key_low_reg, key_low_next;
    logic [63:0] key_mid_reg, key_mid_next;
    logic [31:0] key_high_reg, key_high_next;
    logic [4:0]  len_reg, len_next;
    logic [7:0]  slot_reg, slot_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  found_reg, found_next;

    // Request masking
    logic [4:0]                   len_sat;
    logic [MAX_KEY_BYTES*8-1:0]   key_in;
    logic [MAX_KEY_BYTES*8-1:0]   key_mask;
    logic [159:0]                 key_masked;

    // Entry checks
    logic key_hit;
    logic slot_hit;
    logic last_eval;
    logic finish;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Saturate the length and zero every byte at or beyond it
    always_comb
    begin
        len_sat = (int'(cid_length) > MAX_KEY_BYTES) ? 5'(MAX_KEY_BYTES) : cid_length;
        key_in  = (MAX_KEY_BYTES*8)'({cid_bytes_16_19, cid_bytes_8_15, cid_bytes_0_7});
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            key_mask[i*8 +: 8] = (i < int'(len_sat)) ? 8'hff : 8'h00;
        end
        key_masked = 160'(key_in & key_mask);
    end

    assign key_hit  = rdata_reg.valid && (rdata_reg.key_len == len_reg) &&
                      (rdata_reg.key_low == key_low_reg) &&
                      (rdata_reg.key_mid == key_mid_reg) &&
                      (rdata_reg.key_high == key_high_reg);
    assign slot_hit  = rdata_reg.valid && (rdata_reg.owner == slot_reg);
    assign last_eval = (eval_addr_reg == LAST_ADDR);

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        eval_vld_next  = 1'b0;
        eval_addr_next = eval_addr_reg;
        done_next      = 1'b0;
        act_next       = act_reg;
        key_low_next   = key_low_reg;
        key_mid_next   = key_mid_reg;
        key_high_next  = key_high_reg;
        len_next       = len_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        mem_we         = 1'b0;
        mem_waddr      = eval_addr_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = issue_cnt_reg[ADDR_W-1:0];
        finish         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep: write every entry invalid
                mem_we    = 1'b1;
                mem_waddr = issue_cnt_reg[ADDR_W-1:0];
                if (issue_cnt_reg[ADDR_W-1:0] == LAST_ADDR)
                begin
                    issue_cnt_next = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    act_next      = action;
                    key_low_next  = key_masked[63:0];
                    key_mid_next  = key_masked[127:64];
                    key_high_next = key_masked[159:128];
                    len_next      = len_sat;
                    slot_next     = owner_slot;
                    if (action == ACT_INSERT && int'(owner_slot) >= SLOT_COUNT)
                    begin
                        // Slot out of range: drop the insert, answer at once
                        done_next   = 1'b1;
                        status_next = STS_OK;
                        found_next  = '0;
                    end
                    else
                    begin
                        issue_cnt_next = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (eval_vld_reg)
                begin
                    unique case (act_reg)
                        ACT_LOOKUP:
                        begin
                            if (key_hit)
                            begin
                                finish      = 1'b1;
                                status_next = STS_OK;
                                found_next  = rdata_reg.owner;
                            end
                            else if (last_eval)
                            begin
                                finish      = 1'b1;
                                status_next = STS_MISS;
                                found_next  = '0;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (!rdata_reg.valid)
                            begin
                                mem_we             = 1'b1;
                                mem_wdata.valid    = 1'b1;
                                mem_wdata.key_low  = key_low_reg;
                                mem_wdata.key_mid  = key_mid_reg;
                                mem_wdata.key_high = key_high_reg;
                                mem_wdata.key_len  = len_reg;
                                mem_wdata.owner    = slot_reg;
                                finish             = 1'b1;
                                status_next        = STS_OK;
                                found_next         = '0;
                            end
                            else if (last_eval)
                            begin
                                finish      = 1'b1;
                                status_next = STS_FULL;
                                found_next  = '0;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (key_hit)
                            begin
                                mem_we = 1'b1;
                            end
                            if (key_hit || last_eval)
                            begin
                                finish      = 1'b1;
                                status_next = STS_OK;
                                found_next  = '0;
                            end
                        end
                        ACT_REMOVE_ALL:
                        begin
                            // Clear each owned entry and keep walking
                            if (slot_hit)
                            begin
                                mem_we = 1'b1;
                            end
                            if (last_eval)
                            begin
                                finish      = 1'b1;
                                status_next = STS_OK;
                                found_next  = '0;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end

                if (finish)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (issue_cnt_reg < CNT_W'(TABLE_DEPTH))
                begin
                    // Read one entry ahead of the one being checked
                    mem_re         = 1'b1;
                    eval_vld_next  = 1'b1;
                    eval_addr_next = issue_cnt_reg[ADDR_W-1:0];
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            issue_cnt_reg <= '0;
            eval_vld_reg  <= 1'b0;
            eval_addr_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            eval_vld_reg  <= eval_vld_next;
            eval_addr_reg <= eval_addr_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_low_reg  <= key_low_next;
        key_mid_reg  <= key_mid_next;
        key_high_reg <= key_high_next;
        len_reg      <= len_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign found_slot = found_reg;

endmodule

@@ sim/connection_id_table_tb.sv @@
// ----------------------------------------------------------------------------
// connection_id_table_tb
// Self-checking bench for the connection identifier table. A queue of request
// words feeds a falling-edge driver that sends them in bursts with random
// gaps. A rising-edge monitor predicts each accepted word against its own
// shadow copy of the table and compares every result word field by field.
// The stimulus runs a short directed set, then a random mix, then a directed
// tail of inserts, lookups and removes around a marker key.
// ----------------------------------------------------------------------------
module connection_id_table_tb;

    import cidt_pkg::*;

    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int RANDOM_WORDS = 245;
    localparam int POOL_DEPTH   = 48;
    localparam int PRINT_LIMIT  = 100;

    // One request word; key byte i sits at bits 8i+7..8i
    typedef struct packed {
        logic [1:0]   action;
        logic [159:0] key;
        logic [4:0]   length;
        logic [7:0]   slot;
    } request_t;

    // One result word as the table should answer it
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] slot;
    } answer_t;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        start           = 1'b0;
    logic        busy;
    logic [1:0]  action          = ACT_LOOKUP;
    logic [63:0] cid_bytes_0_7   = '0;
    logic [63:0] cid_bytes_8_15  = '0;
    logic [31:0] cid_bytes_16_19 = '0;
    logic [4:0]  cid_length      = '0;
    logic [7:0]  owner_slot      = '0;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  found_slot;

    // Shadow copy of the table, updated at the edge each word is taken
    entry_t   shadow_table [TABLE_DEPTH];

    request_t request_backlog [$];
    answer_t  pending_answers [$];
    request_t key_pool [$];        // recent inserts, reused to hit stored keys

    request_t next_word;
    int       burst_left    = 0;
    int       gap_left      = 0;
    bit       req_accepted  = 1'b0;
    int       cycle_count   = 0;
    int       mismatch_count = 0;

    connection_id_table u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .cid_bytes_0_7   (cid_bytes_0_7),
        .cid_bytes_8_15  (cid_bytes_8_15),
        .cid_bytes_16_19 (cid_bytes_16_19),
        .cid_length      (cid_length),
        .owner_slot      (owner_slot),
        .done            (done),
        .status          (status),
        .found_slot      (found_slot)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------------

    // Lengths above the key size count as the full key
    function automatic int saturated_length(logic [4:0] len);
        return (int'(len) > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(len);
    endfunction

    // Bytes that take part in a compare; the rest are stored as zero
    function automatic logic [159:0] kept_bytes_mask(int n);
        logic [159:0] mask;
        mask = '0;
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            if (i < n)
                mask[8*i +: 8] = 8'hFF;
        end
        return mask;
    endfunction

    function automatic bit entry_holds(int e, logic [159:0] key, int n);
        return shadow_table[e].valid && int'(shadow_table[e].key_len) == n &&
               {shadow_table[e].key_high, shadow_table[e].key_mid,
                shadow_table[e].key_low} == key;
    endfunction

    // Apply one request to the shadow table and return the answer it earns
    function automatic answer_t predict_table_answer(request_t req);
        answer_t      ans;
        int           n;
        logic [159:0] key;
        bit           settled;
        n           = saturated_length(req.length);
        key         = req.key & kept_bytes_mask(n);
        ans.status  = STS_OK;
        ans.slot    = '0;
        settled     = 1'b0;
        case (req.action)
            ACT_LOOKUP:
            begin
                // lowest matching entry wins
                ans.status = STS_MISS;
                for (int e = 0; e < TABLE_DEPTH && !settled; e++)
                begin
                    if (entry_holds(e, key, n))
                    begin
                        ans.status = STS_OK;
                        ans.slot   = shadow_table[e].owner;
                        settled    = 1'b1;
                    end
                end
            end
            ACT_INSERT:
            begin
                // no duplicate check; take the lowest free entry
                if (int'(req.slot) < SLOT_COUNT)
                begin
                    ans.status = STS_FULL;
                    for (int e = 0; e < TABLE_DEPTH && !settled; e++)
                    begin
                        if (!shadow_table[e].valid)
                        begin
                            shadow_table[e] = {1'b1, key[63:0], key[127:64],
                                               key[159:128], 5'(n), req.slot};
                            ans.status = STS_OK;
                            settled    = 1'b1;
                        end
                    end
                end
            end
            ACT_REMOVE:
            begin
                for (int e = 0; e < TABLE_DEPTH && !settled; e++)
                begin
                    if (entry_holds(e, key, n))
                    begin
                        shadow_table[e].valid = 1'b0;
                        settled               = 1'b1;
                    end
                end
            end
            ACT_REMOVE_ALL:
            begin
                for (int e = 0; e < TABLE_DEPTH; e++)
                begin
                    if (shadow_table[e].valid && shadow_table[e].owner == req.slot)
                        shadow_table[e].valid = 1'b0;
                end
            end
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly mid-range lengths, with zero, full and overlong ones mixed in
    function automatic logic [4:0] random_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 5'd0;
        if (pick < 4)
            return 5'(MAX_KEY_BYTES);
        if (pick < 6)
            return 5'($urandom_range(21, 31));
        return 5'($urandom_range(1, 19));
    endfunction

    // Favor a few slots so remove-slot finds several entries to clear
    function automatic logic [7:0] random_owner();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return 8'($urandom_range(0, 7));
        if (pick == 7)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [159:0] random_bytes();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic request_t fresh_request(logic [1:0] act, logic [4:0] len,
                                               logic [7:0] slot);
        return {act, random_bytes(), len, slot};
    endfunction

    // Reuse a recently inserted key, sometimes with junk past the length,
    // an overlong length, one changed byte or a shorter length
    function automatic request_t recalled_request(logic [1:0] act);
        request_t     req;
        int           n;
        int           pick;
        int           idx;
        logic [159:0] mask;
        if (key_pool.size() == 0)
            return fresh_request(act, random_length(), random_owner());
        req        = key_pool[$urandom_range(0, key_pool.size() - 1)];
        req.action = act;
        n          = saturated_length(req.length);
        mask       = kept_bytes_mask(n);
        pick       = $urandom_range(0, 9);
        if (pick < 3)
            req.key = (req.key & mask) | (random_bytes() & ~mask);
        else if (pick == 3 && n == MAX_KEY_BYTES)
            req.length = 5'($urandom_range(MAX_KEY_BYTES, 31));
        else if (pick == 4 && n > 0)
        begin
            idx = $urandom_range(0, n - 1);
            req.key[8*idx +: 8] = req.key[8*idx +: 8] ^ 8'($urandom_range(1, 255));
        end
        else if (pick == 5)
            req.length = (n == 0) ? 5'd1 : 5'(n - 1);
        return req;
    endfunction

    task automatic queue_word(request_t req);
        request_backlog.push_back(req);
        if (req.action == ACT_INSERT)
        begin
            key_pool.push_back(req);
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endtask

    // Return once every queued word is sent and answered
    task automatic wait_until_drained();
        while (request_backlog.size() != 0 || start || pending_answers.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present words at the falling edge. A word stays on the ports
    // until the monitor sees it taken; after each burst hold start low for a
    // random number of idle (not busy) cycles, sometimes none at all.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !req_accepted)
        begin
            // hold the current word until the table takes it
        end
        else
        begin
            req_accepted = 1'b0;
            if (gap_left > 0)
            begin
                start <= 1'b0;
                if (!busy)
                    gap_left--;
            end
            else if (request_backlog.size() > 0)
            begin
                next_word       = request_backlog.pop_front();
                action          <= next_word.action;
                cid_bytes_0_7   <= next_word.key[63:0];
                cid_bytes_8_15  <= next_word.key[127:64];
                cid_bytes_16_19 <= next_word.key[159:128];
                cid_length      <= next_word.length;
                owner_slot      <= next_word.slot;
                start           <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge check a finished word first (it belongs to
    // an earlier request), then predict a word taken at this same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        answer_t oldest;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch("result word with no request outstanding");
                else
                begin
                    oldest = pending_answers.pop_front();
                    if (status !== oldest.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, oldest.status));
                    if (found_slot !== oldest.slot)
                        report_mismatch($sformatf("found_slot %0d, expected %0d",
                                                  found_slot, oldest.slot));
                end
            end
            if (start && !busy)
            begin
                pending_answers.push_back(predict_table_answer({action,
                    cid_bytes_16_19, cid_bytes_8_15, cid_bytes_0_7, cid_length,
                    owner_slot}));
                req_accepted = 1'b1;
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int       pick;
        request_t last_fill;
        request_t marker;

        for (int e = 0; e < TABLE_DEPTH; e++)
            shadow_table[e] = '0;

        // Directed: empty table, zero length, full and overlong keys,
        // duplicates, junk past the length, misses on near lengths,
        // remove without a match and remove-slot with and without entries.
        queue_word({ACT_LOOKUP,     160'h0,       5'd0,  8'h00});
        queue_word({ACT_INSERT,     160'h0,       5'd0,  8'h00});
        queue_word({ACT_LOOKUP,     {160{1'b1}},  5'd0,  8'h33});
        queue_word({ACT_INSERT,     {160{1'b1}},  5'd20, 8'hFF});
        queue_word({ACT_LOOKUP,     {160{1'b1}},  5'd31, 8'h00});
        queue_word({ACT_INSERT,     {160{1'b1}},  5'd25, 8'h5A});
        queue_word({ACT_LOOKUP,     {160{1'b1}},  5'd20, 8'h00});
        queue_word({ACT_REMOVE,     {160{1'b1}},  5'd20, 8'h00});
        queue_word({ACT_LOOKUP,     {160{1'b1}},  5'd20, 8'h00});
        queue_word({ACT_REMOVE,     160'hC0FFEE,  5'd3,  8'h00});
        queue_word({ACT_INSERT,     {96'hDEAD_BEEF_0BAD_F00D_1234_5678,
                                     64'h0123_4567_89AB_CDEF}, 5'd8, 8'h81});
        queue_word({ACT_LOOKUP,     {96'h0, 64'h0123_4567_89AB_CDEF}, 5'd8, 8'h00});
        queue_word({ACT_LOOKUP,     {96'h0, 64'h0123_4567_89AB_CDEF}, 5'd9, 8'h00});
        queue_word({ACT_LOOKUP,     {96'h0, 64'h0123_4567_89AB_CDEF}, 5'd7, 8'h00});
        queue_word({ACT_INSERT,     160'h80,      5'd1,  8'h81});
        queue_word({ACT_REMOVE_ALL, 160'h0,       5'd0,  8'h81});
        queue_word({ACT_LOOKUP,     {96'h0, 64'h0123_4567_89AB_CDEF}, 5'd8, 8'h00});
        queue_word({ACT_REMOVE_ALL, {160{1'b1}},  5'd31, 8'hC3});
        queue_word({ACT_LOOKUP,     160'h80,      5'd1,  8'h00});
        queue_word({ACT_REMOVE_ALL, 160'h0,       5'd0,  8'h5A});
        queue_word({ACT_LOOKUP,     {160{1'b1}},  5'd20, 8'h00});
        queue_word({ACT_REMOVE_ALL, 160'h0,       5'd0,  8'h00});
        queue_word({ACT_LOOKUP,     160'h0,       5'd0,  8'h00});

        // Random mix: most lookups and removes reuse stored keys so they hit
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_word(($urandom_range(0, 4) != 0) ? recalled_request(ACT_LOOKUP)
                           : fresh_request(ACT_LOOKUP, random_length(), random_owner()));
            else if (pick < 70)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    next_word      = recalled_request(ACT_INSERT);
                    next_word.slot = random_owner();
                    queue_word(next_word);
                end
                else
                    queue_word(fresh_request(ACT_INSERT, random_length(), random_owner()));
            end
            else if (pick < 90)
                queue_word(($urandom_range(0, 3) != 0) ? recalled_request(ACT_REMOVE)
                           : fresh_request(ACT_REMOVE, random_length(), random_owner()));
            else
                queue_word(fresh_request(ACT_REMOVE_ALL, random_length(), random_owner()));
        end

        // Reset once; the table then clears itself with busy high
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        wait_until_drained();

        // Tail: inserts, hits and removes around a marker key
        last_fill = fresh_request(ACT_INSERT, random_length(), 8'h10);
        queue_word(last_fill);
        queue_word(fresh_request(ACT_INSERT, 5'd20, 8'h40));
        queue_word(fresh_request(ACT_INSERT, 5'd31, 8'h41));
        queue_word({ACT_LOOKUP, last_fill.key, last_fill.length, 8'h00});
        queue_word(fresh_request(ACT_LOOKUP, 5'd20, 8'h00));
        queue_word({ACT_REMOVE, last_fill.key, last_fill.length, 8'h00});
        marker = fresh_request(ACT_INSERT, 5'd20, 8'hFF);
        queue_word(marker);
        queue_word(fresh_request(ACT_INSERT, 5'd12, 8'h42));
        queue_word(fresh_request(ACT_REMOVE_ALL, 5'd0, 8'h10));
        queue_word(fresh_request(ACT_INSERT, 5'd5, 8'hFE));
        queue_word({ACT_LOOKUP, marker.key, marker.length, 8'h00});
        queue_word(fresh_request(ACT_REMOVE_ALL, 5'd0, 8'hFF));
        queue_word({ACT_LOOKUP, marker.key, marker.length, 8'h00});
        for (int s = 17; s <= 23; s++)
            queue_word(fresh_request(ACT_REMOVE_ALL, random_length(), 8'(s)));
        queue_word(fresh_request(ACT_LOOKUP, random_length(), 8'h00));

        wait_until_drained();

        // Leave room for any stray result word before deciding
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/cidt_pkg.sv
src/connection_id_table.sv
sim/connection_id_table_tb.sv
